@@ src/imf_pkg.sv @@
// ----------------------------------------------------------------------------
// imf_pkg
// Shared constants, CORDIC arctangent table and saturation helper for the
// complementary attitude filter.
// ----------------------------------------------------------------------------
package imf_pkg;

  localparam int TAB_LEN          = 28;
  localparam int CORDIC_STEPS_DEF = 20;

  localparam logic signed [24:0] ANG_MAX  = 25'sd11796480;
  localparam logic signed [33:0] ANG_MAX34  = 34'sd11796480;
  localparam logic signed [33:0] ANG_FULL34 = 34'sd23592960;

  localparam logic [17:0] LPF_W  = 18'd13107;
  localparam logic [17:0] LPF_WC = 18'd52429;

  localparam logic [1:0] REG_BLEND = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_SPIKE = 2'd2;
  localparam logic [1:0] REG_GUARD = 2'd3;

  // atan(2^-i) in Q7.24 degrees
  function automatic logic [30:0] atan_lut(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd754974720;
      5'd1:  v = 31'd445687602;
      5'd2:  v = 31'd235489088;
      5'd3:  v = 31'd119537938;
      5'd4:  v = 31'd60000934;
      5'd5:  v = 31'd30029717;
      5'd6:  v = 31'd15018523;
      5'd7:  v = 31'd7509720;
      5'd8:  v = 31'd3754917;
      5'd9:  v = 31'd1877466;
      5'd10: v = 31'd938734;
      5'd11: v = 31'd469367;
      5'd12: v = 31'd234684;
      5'd13: v = 31'd117342;
      5'd14: v = 31'd58671;
      5'd15: v = 31'd29335;
      5'd16: v = 31'd14668;
      5'd17: v = 31'd7334;
      5'd18: v = 31'd3667;
      5'd19: v = 31'd1833;
      5'd20: v = 31'd917;
      5'd21: v = 31'd458;
      5'd22: v = 31'd229;
      5'd23: v = 31'd115;
      5'd24: v = 31'd57;
      5'd25: v = 31'd29;
      5'd26: v = 31'd14;
      5'd27: v = 31'd7;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [24:0] sat_ang(input logic signed [36:0] v);
    logic signed [24:0] r;
    if (v > 37'(ANG_MAX)) r = ANG_MAX;
    else if (v < -37'(ANG_MAX)) r = -ANG_MAX;
    else r = v[24:0];
    return r;
  endfunction

endpackage

@@ src/imu_complementary_attitude_filter_top.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_top
// Six-axis complementary attitude filter on one shared multiplier, a bit-serial
// square root and an iterative CORDIC.
// ----------------------------------------------------------------------------
// One sample is handled in steps: the squares of the three accel axes, then for
// pitch and for roll a load, the square root and the CORDIC iterations, then the
// multiply steps and an output step, which waits while an earlier result is
// still held unaccepted. A new sample is taken only once the last one is done.
// The sample rate is set by the single shared multiplier and the one square
// root and CORDIC unit, used in turn for both angles. in_tready is high only
// while the block waits for a sample; a finished result sits in the output
// register while the next sample is accepted.
module imu_complementary_attitude_filter_top
  import imf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each)
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pitch_angle[24:0], roll_angle[49:25], yaw_angle[74:50],
  // rate_z_smoothed[98:75], zero fill
  output logic [103:0] out_tdata,
  // spike_flag
  output logic         out_tuser,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int CORD_N = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam logic [4:0] CORD_LAST = 5'(CORD_N - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_CORD = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_r;
  logic [4:0] cnt_r;
  logic       sel_r;

  logic [15:0] blend_w_r, spike_thr_r;
  logic [31:0] step_r;
  logic [30:0] guard_r;

  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic [30:0] sqx_r, sqy_r, sqz_r;

  logic signed [24:0] pitch_r, roll_r, yaw_r, hold_p_r, hold_r_r;
  logic signed [23:0] filt_r;
  logic signed [15:0] prev_r;
  logic               first_r;

  logic [47:0] rad_r;
  logic [25:0] rem_r;
  logic [23:0] root_r;
  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic signed [33:0] pg_r, rg_r;
  logic signed [52:0] acc_r;

  logic out_valid_r;
  logic [103:0] out_data_r;
  logic out_user_r;

  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_p;

  logic [31:0] sumsq;
  logic        guard_ok;
  logic [27:0] rem_sh, trial, rem_diff;
  logic        take_bit;
  logic [23:0] root_nxt;
  logic signed [33:0] xs, ys, x_nxt, y_nxt;
  logic signed [32:0] z_nxt, z_rnd;
  logic signed [15:0] num;
  logic signed [51:0] p_rnd;
  logic signed [33:0] inc;
  logic signed [52:0] acc_sum, acc_rnd;
  logic signed [33:0] yg, yw1, yw2;
  logic [16:0] w_c;
  logic signed [16:0] jump, jump_abs;

  assign mul_p = mul_a * mul_b;
  assign w_c   = 17'h10000 - {1'b0, blend_w_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        case (cnt_r)
          5'd0:    begin mul_a = 34'(ax_r); mul_b = 18'(ax_r); end
          5'd1:    begin mul_a = 34'(ay_r); mul_b = 18'(ay_r); end
          default: begin mul_a = 34'(az_r); mul_b = 18'(az_r); end
        endcase
      end
      ST_MUL: begin
        case (cnt_r)
          5'd0: begin mul_a = {2'b00, step_r}; mul_b = 18'(gy_r); end
          5'd1: begin mul_a = {2'b00, step_r}; mul_b = 18'(gx_r); end
          5'd2: begin mul_a = {2'b00, step_r}; mul_b = 18'(gz_r); end
          5'd3: begin mul_a = 34'(hold_p_r); mul_b = {2'b00, blend_w_r}; end
          5'd4: begin mul_a = pg_r; mul_b = {1'b0, w_c}; end
          5'd5: begin mul_a = 34'(hold_r_r); mul_b = {2'b00, blend_w_r}; end
          5'd6: begin mul_a = rg_r; mul_b = {1'b0, w_c}; end
          5'd7: begin mul_a = {{10{gz_r[15]}}, gz_r, 8'd0}; mul_b = LPF_W; end
          default: begin mul_a = 34'(filt_r); mul_b = LPF_WC; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sumsq    = sel_r ? ({1'b0, sqx_r} + {1'b0, sqz_r}) : ({1'b0, sqy_r} + {1'b0, sqz_r});
    guard_ok = sumsq > {1'b0, guard_r};
    num      = sel_r ? ay_r : ax_r;

    rem_sh   = {rem_r, rad_r[47:46]};
    trial    = {2'b00, root_r, 2'b01};
    take_bit = rem_sh >= trial;
    rem_diff = rem_sh - trial;
    root_nxt = {root_r[22:0], take_bit};

    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    if (!y_r[33] && (y_r != 34'sd0)) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + $signed({2'b00, atan_lut(cnt_r)});
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - $signed({2'b00, atan_lut(cnt_r)});
    end
    z_rnd = z_nxt + 33'sd128;

    p_rnd   = mul_p + 52'sd32768;
    inc     = p_rnd[49:16];
    acc_sum = acc_r + 53'(mul_p);
    acc_rnd = acc_sum + 53'sd32768;

    yg  = 34'(yaw_r) + inc;
    yw1 = (yg > ANG_MAX34) ? (yg - ANG_FULL34) : yg;
    yw2 = (yw1 < -ANG_MAX34) ? (yw1 + ANG_FULL34) : yw1;

    jump     = 17'(gz_r) - 17'(prev_r);
    jump_abs = jump[16] ? -jump : jump;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_w_r   <= 16'd1311;
      step_r      <= 32'd1309500;
      spike_thr_r <= 16'd1640;
      guard_r     <= 31'd1677;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BLEND: blend_w_r   <= cfg_wdata[15:0];
        REG_STEP:  step_r      <= cfg_wdata;
        REG_SPIKE: spike_thr_r <= cfg_wdata[15:0];
        REG_GUARD: guard_r     <= cfg_wdata[30:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pitch_r     <= '0;
      roll_r      <= '0;
      yaw_r       <= '0;
      hold_p_r    <= '0;
      hold_r_r    <= '0;
      filt_r      <= '0;
      prev_r      <= '0;
      first_r     <= 1'b1;
    end else begin
      if (out_valid_r && out_tready && (state_r != ST_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            ax_r    <= in_tdata[15:0];
            ay_r    <= in_tdata[31:16];
            az_r    <= in_tdata[47:32];
            gx_r    <= in_tdata[63:48];
            gy_r    <= in_tdata[79:64];
            gz_r    <= in_tdata[95:80];
            cnt_r   <= '0;
            sel_r   <= 1'b0;
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          case (cnt_r)
            5'd0:    sqx_r <= mul_p[30:0];
            5'd1:    sqy_r <= mul_p[30:0];
            default: sqz_r <= mul_p[30:0];
          endcase
          if (cnt_r == 5'd2) state_r <= ST_LOAD;
          cnt_r <= cnt_r + 5'd1;
        end
        ST_LOAD: begin
          rad_r   <= {sumsq[31:0], 16'd0};
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          rem_r  <= take_bit ? rem_diff[25:0] : rem_sh[25:0];
          root_r <= root_nxt;
          rad_r  <= {rad_r[45:0], 2'b00};
          if (cnt_r == 5'd23) begin
            x_r     <= {4'd0, root_nxt, 6'd0};
            y_r     <= {{4{num[15]}}, num, 14'd0};
            z_r     <= '0;
            cnt_r   <= '0;
            state_r <= ST_CORD;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_CORD: begin
          x_r <= x_nxt;
          y_r <= y_nxt;
          z_r <= z_nxt;
          if (cnt_r == CORD_LAST) begin
            if (guard_ok) begin
              if (sel_r) hold_r_r <= z_rnd[32:8];
              else hold_p_r <= z_rnd[32:8];
            end
            cnt_r <= '0;
            if (sel_r) begin
              state_r <= ST_MUL;
            end else begin
              sel_r   <= 1'b1;
              state_r <= ST_LOAD;
            end
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_MUL: begin
          case (cnt_r)
            5'd0: pg_r <= 34'(pitch_r) + inc;
            5'd1: rg_r <= 34'(roll_r) + inc;
            5'd2: yaw_r <= first_r ? 25'sd0 : sat_ang(37'(yw2));
            5'd3: acc_r <= 53'(mul_p);
            5'd4: pitch_r <= first_r ? hold_p_r : sat_ang(acc_rnd[52:16]);
            5'd5: acc_r <= 53'(mul_p);
            5'd6: roll_r <= first_r ? hold_r_r : sat_ang(acc_rnd[52:16]);
            5'd7: acc_r <= 53'(mul_p);
            default: filt_r <= first_r ? {gz_r, 8'd0} : acc_rnd[39:16];
          endcase
          if (cnt_r == 5'd8) state_r <= ST_DONE;
          cnt_r <= cnt_r + 5'd1;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {5'd0, filt_r, yaw_r, roll_r, pitch_r};
            out_user_r  <= first_r ? 1'b0 : (jump_abs > $signed({1'b0, spike_thr_r}));
            prev_r      <= gz_r;
            first_r     <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/imf_checker.sv @@
// ----------------------------------------------------------------------------
// imf_checker
// Port-level checks for the complementary attitude filter, bound to the top.
// ----------------------------------------------------------------------------
module imf_checker
  import imf_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output transaction changed");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[24:0]) <= ANG_MAX &&
                    $signed(out_tdata[24:0]) >= -ANG_MAX))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[74:50]) <= ANG_MAX &&
                    $signed(out_tdata[74:50]) >= -ANG_MAX))
    else $error("yaw out of range");

endmodule

bind imu_complementary_attitude_filter_top imf_checker u_imf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
